>>> src/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants for the lru key cache tracker
// Request and result payloads, the scan record that ripples along the row of
// entry cells, and the update command broadcast to every cell.
// ----------------------------------------------------------------------------
package lkc_pkg;

  // default geometry
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  // widest record fields (ENTRIES up to 64, KEY_BITS up to 63 plus side bit)
  localparam int IDX_MAX_W = 6;
  localparam int TAG_MAX_W = 64;

  // fixed payload widths
  localparam int KEY_W  = 32;
  localparam int SLOT_W = 4;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // cell update operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_HIT  = 2'd1;
  localparam logic [1:0] OP_MISS = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             side;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic              evicted_side;
  } rsp_t;

  // running result of one pass along the cell row
  typedef struct packed {
    logic                 valid;
    logic                 hit_found;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic [IDX_MAX_W-1:0] hit_age;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
    logic                 old_found;
    logic [IDX_MAX_W-1:0] old_idx;
    logic [IDX_MAX_W-1:0] old_age;
    logic [TAG_MAX_W-1:0] old_tag;
    logic                 old2_found;
    logic [IDX_MAX_W-1:0] old2_idx;
    logic [IDX_MAX_W-1:0] old2_age;
    logic [TAG_MAX_W-1:0] old2_tag;
  } scan_rec_t;

  // update broadcast to all cells; tag also serves as the search tag
  typedef struct packed {
    logic [1:0]           op;
    logic [IDX_MAX_W-1:0] slot;
    logic [IDX_MAX_W-1:0] ref_age;
    logic                 evict_en;
    logic [IDX_MAX_W-1:0] evict_idx;
    logic [TAG_MAX_W-1:0] tag;
  } cell_cmd_t;

endpackage

>>> src/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell: one entry of the lru tag store
// Holds valid, tag and age of one entry. Folds its entry into the scan record
// handed from the previous cell and registers it for the next one, and applies
// the broadcast hit or miss update to its own age and tag.
// ----------------------------------------------------------------------------
module lkc_cell #(
  parameter int ENTRIES  = lkc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkc_pkg::DEF_KEY_BITS,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lkc_pkg::scan_rec_t  rec_in,
  output lkc_pkg::scan_rec_t  rec_out,
  input  lkc_pkg::cell_cmd_t  cmd
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_W = KEY_BITS + 1;

  logic             valid;
  logic [IDX_W-1:0] age;
  logic [TAG_W-1:0] key;

  logic [lkc_pkg::IDX_MAX_W-1:0] my_idx;
  logic [lkc_pkg::IDX_MAX_W-1:0] my_age;
  logic [lkc_pkg::TAG_MAX_W-1:0] my_tag;
  logic                          match;
  logic                          is_slot;
  logic                          is_victim;
  lkc_pkg::scan_rec_t            rec_next;

  assign my_idx    = lkc_pkg::IDX_MAX_W'(INDEX);
  assign my_age    = lkc_pkg::IDX_MAX_W'(age);
  assign my_tag    = lkc_pkg::TAG_MAX_W'(key);
  assign match     = valid && (key == cmd.tag[TAG_W-1:0]);
  assign is_slot   = (cmd.slot[IDX_W-1:0] == IDX_W'(INDEX));
  assign is_victim = cmd.evict_en && (cmd.evict_idx[IDX_W-1:0] == IDX_W'(INDEX));

  // fold this entry into the passing record
  always_comb begin
    rec_next = rec_in;
    if (match && !rec_in.hit_found) begin
      rec_next.hit_found = 1'b1;
      rec_next.hit_idx   = my_idx;
      rec_next.hit_age   = my_age;
    end
    if (!valid && !rec_in.free_found) begin
      rec_next.free_found = 1'b1;
      rec_next.free_idx   = my_idx;
    end
    if (valid) begin
      if (!rec_in.old_found || (my_age > rec_in.old_age)) begin
        rec_next.old2_found = rec_in.old_found;
        rec_next.old2_idx   = rec_in.old_idx;
        rec_next.old2_age   = rec_in.old_age;
        rec_next.old2_tag   = rec_in.old_tag;
        rec_next.old_found  = 1'b1;
        rec_next.old_idx    = my_idx;
        rec_next.old_age    = my_age;
        rec_next.old_tag    = my_tag;
      end else if (!rec_in.old2_found || (my_age > rec_in.old2_age)) begin
        rec_next.old2_found = 1'b1;
        rec_next.old2_idx   = my_idx;
        rec_next.old2_age   = my_age;
        rec_next.old2_tag   = my_tag;
      end
    end
  end

  // hand the record to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
    end
  end

  // entry valid and age
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else begin
      case (cmd.op)
        lkc_pkg::OP_HIT: begin
          if (is_victim) begin
            valid <= 1'b0;
            age   <= '0;
          end else if (is_slot) begin
            age <= '0;
          end else if (valid && (age < cmd.ref_age[IDX_W-1:0])) begin
            age <= age + 1'b1;
          end
        end
        lkc_pkg::OP_MISS: begin
          if (is_slot) begin
            valid <= 1'b1;
            age   <= '0;
          end else if (valid) begin
            age <= age + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entry tag
  always_ff @(posedge clk) begin
    if ((cmd.op == lkc_pkg::OP_MISS) && is_slot) begin
      key <= cmd.tag[TAG_W-1:0];
    end
  end

endmodule

>>> src/lru_key_cache_tracker.sv
// ----------------------------------------------------------------------------
// lru_key_cache_tracker: fully associative lru tag store
// A row of entry cells is searched by a record that moves one cell per cycle;
// the controller then decides hit, insert or evict and broadcasts one update.
//
//   channel   ports                      transfer
//   request   start, busy, req           start high while busy low
//   result    done, rsp                  done high, one cycle, no stall
//   config    cfg_wr_en, cfg_wr_data     cfg_wr_en high
//
// An item passes through the launch register, the search along the cell row
// and the update; busy stays high throughout, so a new request is taken only
// once the last one is through. The result is on the ports in the cycle where
// busy falls.
// Reset clears all entries at once and sets capacity to 16; no clearing pass.
// done is high for one cycle since the receiver cannot stall; rsp is held.
// ----------------------------------------------------------------------------
module lru_key_cache_tracker #(
  parameter int ENTRIES  = lkc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkc_pkg::DEF_KEY_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  lkc_pkg::req_t             req,
  output logic                      done,
  output lkc_pkg::rsp_t             rsp,
  input  logic                      cfg_wr_en,
  input  logic [lkc_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int TAG_W = KEY_BITS + 1;
  localparam int CMP_W = (CNT_W > lkc_pkg::CAP_W) ? CNT_W : lkc_pkg::CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                      state;
  logic                      launch;
  logic [TAG_W-1:0]          tag;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [lkc_pkg::CAP_W-1:0] capacity;
  lkc_pkg::rsp_t             rsp_next;
  lkc_pkg::cell_cmd_t        cmd;
  lkc_pkg::scan_rec_t        scan_chain [ENTRIES+1];
  lkc_pkg::scan_rec_t        fin;

  logic                      accept;
  logic [KEY_BITS+31:0]      key_wide;
  logic [CMP_W-1:0]          cap_ext;
  logic [CMP_W-1:0]          cnt_ext;
  logic [CMP_W-1:0]          eff_cap;
  logic [IDX_W-1:0]          slot_idx;
  logic [IDX_W+3:0]          slot_wide;
  logic [TAG_W-1:0]          ev_tag;
  logic [KEY_BITS+31:0]      ev_wide;
  logic                      ev;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign key_wide = {{KEY_BITS{1'b0}}, req.key_value};
  assign fin      = scan_chain[ENTRIES];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      launch <= accept;
      done   <= fin.valid;
      if (accept) begin
        state <= ST_SCAN;
      end else if (fin.valid) begin
        state <= ST_IDLE;
        count <= count_next;
      end
    end
  end

  // request tag, side above key
  always_ff @(posedge clk) begin
    if (accept) begin
      tag <= {req.side, key_wide[KEY_BITS-1:0]};
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // effective capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(capacity);
    cnt_ext = CMP_W'(count);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // search record entering the first cell
  always_comb begin
    scan_chain[0]       = '0;
    scan_chain[0].valid = launch;
  end

  // row of entry cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkc_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .rec_in  (scan_chain[i]),
      .rec_out (scan_chain[i+1]),
      .cmd     (cmd)
    );
  end

  // decide hit, insert or eviction from the finished record
  always_comb begin
    cmd           = '0;
    cmd.op        = lkc_pkg::OP_NONE;
    cmd.tag       = lkc_pkg::TAG_MAX_W'(tag);
    count_next    = count;
    slot_idx      = '0;
    ev            = 1'b0;
    ev_tag        = '0;
    rsp_next      = '0;
    if (fin.valid) begin
      if (fin.hit_found) begin
        cmd.op        = lkc_pkg::OP_HIT;
        cmd.ref_age   = fin.hit_age;
        slot_idx      = fin.hit_idx[IDX_W-1:0];
        rsp_next.hit  = 1'b1;
        if (cnt_ext > eff_cap) begin
          // oldest after the update: the runner-up when the hit was the oldest
          if (fin.old_idx == fin.hit_idx) begin
            if (fin.old2_found) begin
              ev            = 1'b1;
              cmd.evict_idx = fin.old2_idx;
              ev_tag        = fin.old2_tag[TAG_W-1:0];
            end
          end else if (fin.old_found) begin
            ev            = 1'b1;
            cmd.evict_idx = fin.old_idx;
            ev_tag        = fin.old_tag[TAG_W-1:0];
          end
          if (ev) begin
            cmd.evict_en = 1'b1;
            count_next   = count - CNT_W'(1);
          end
        end
      end else begin
        cmd.op = lkc_pkg::OP_MISS;
        if ((cnt_ext < eff_cap) && fin.free_found) begin
          slot_idx   = fin.free_idx[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end else if (fin.old_found) begin
          slot_idx = fin.old_idx[IDX_W-1:0];
          ev       = 1'b1;
          ev_tag   = fin.old_tag[TAG_W-1:0];
        end else begin
          slot_idx   = '0;
          count_next = count + CNT_W'(1);
        end
      end
      cmd.slot              = lkc_pkg::IDX_MAX_W'(slot_idx);
      rsp_next.slot         = slot_wide[3:0];
      rsp_next.evicted      = ev;
      rsp_next.evicted_key  = ev_wide[31:0];
      rsp_next.evicted_side = ev_tag[KEY_BITS];
    end
  end

  assign slot_wide = {4'b0000, slot_idx};
  assign ev_wide   = {32'h0000_0000, ev_tag[KEY_BITS-1:0]};

  // result register
  always_ff @(posedge clk) begin
    if (fin.valid) begin
      rsp <= rsp_next;
    end
  end

  // a result only ends a search
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_SCAN)
    else $error("result without a search in progress");

  // results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results for one request");

  // a hit never evicts its own entry
  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.evict_en |-> (cmd.evict_idx != cmd.slot))
    else $error("eviction targets the entry that hit");

  // entry count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(ENTRIES))
    else $error("entry count beyond store size");

  // search record only arrives while a search runs
  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst)
    fin.valid |-> (state == ST_SCAN) && !launch)
    else $error("search record outside a search");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for lru_key_cache_tracker
// A short table of directed lookups and capacity writes runs first, then
// phases of random lookups drawn mostly from a small pool of keys so that hits,
// fills and evictions all occur; a shadow lru store predicts untyped results.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = lkc_pkg::DEF_ENTRIES;
  localparam int PHASE_ITEMS = 75;

  typedef enum logic [1:0] {ROW_LOOKUP, ROW_CAP} row_kind_t;

  // one directed row; typed rows carry a no-eviction expectation
  typedef struct packed {
    row_kind_t                  kind;
    logic [lkc_pkg::KEY_W-1:0]  key_value;
    logic                       side;
    logic [lkc_pkg::CAP_W-1:0]  cap;
    logic                       typed;
    logic                       want_hit;
    logic [lkc_pkg::SLOT_W-1:0] want_slot;
  } row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  lkc_pkg::req_t             req;
  logic                      done;
  lkc_pkg::rsp_t             rsp;
  logic                      cfg_wr_en;
  logic [lkc_pkg::CAP_W-1:0] cfg_wr_data;

  // shadow copy of the tag store
  logic                      shadow_valid [NUM_ENTRIES];
  logic [lkc_pkg::KEY_W:0]   shadow_tag   [NUM_ENTRIES];
  int                        shadow_age   [NUM_ENTRIES];
  int                        shadow_count;
  logic [lkc_pkg::CAP_W-1:0] shadow_cap;

  lkc_pkg::rsp_t pending_rsp[$];
  int            errors;

  row_t plan [0:21] = '{
    '{ROW_LOOKUP, 32'h0000_0000, 1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b1, 5'd0,  1'b1, 1'b0, 4'd1},
    '{ROW_LOOKUP, 32'h0000_0000, 1'b1, 5'd0,  1'b1, 1'b0, 4'd2},
    '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b0, 5'd0,  1'b1, 1'b0, 4'd3},
    '{ROW_LOOKUP, 32'h0000_0000, 1'b0, 5'd0,  1'b1, 1'b1, 4'd0},
    // capacity lowered below the count: hits evict
    '{ROW_CAP,    32'h0,         1'b0, 5'd1,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b1, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h0000_0000, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h1234_5678, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h1234_5678, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    // zero capacity acts as one
    '{ROW_CAP,    32'h0,         1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'hA5A5_A5A5, 1'b1, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h5A5A_5A5A, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_CAP,    32'h0,         1'b0, 5'd2,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h0000_0001, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h0000_0002, 1'b1, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h0000_0003, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h0000_0001, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    // capacity above the store size acts as full size
    '{ROW_CAP,    32'h0,         1'b0, 5'd31, 1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h8000_0000, 1'b1, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_CAP,    32'h0,         1'b0, 5'd16, 1'b0, 1'b0, 4'd0},
    '{ROW_LOOKUP, 32'h7FFF_FFFF, 1'b0, 5'd0,  1'b0, 1'b0, 4'd0}
  };

  lru_key_cache_tracker uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // valid entry with the largest age, -1 when the store is empty
  function automatic int oldest_entry();
    int pick;
    pick = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (shadow_valid[i] && (pick < 0 || shadow_age[i] > shadow_age[pick])) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  // look up one tag in the shadow store, update it and return the result
  function automatic lkc_pkg::rsp_t lru_lookup(lkc_pkg::req_t item);
    logic [lkc_pkg::KEY_W:0] tag;
    logic [lkc_pkg::KEY_W:0] gone_tag;
    logic                    gone;
    int                      eff_cap;
    int                      idx;
    int                      hit_age;
    int                      victim;
    lkc_pkg::rsp_t           res;
    tag      = {item.side, item.key_value};
    gone     = 1'b0;
    gone_tag = '0;
    idx      = -1;
    eff_cap  = (shadow_cap == 0) ? 1 :
               (shadow_cap > NUM_ENTRIES) ? NUM_ENTRIES : int'(shadow_cap);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (idx < 0 && shadow_valid[i] && shadow_tag[i] == tag) idx = i;
    end
    res.hit = (idx >= 0);
    if (idx >= 0) begin
      // hit: younger entries age by one, hit entry becomes most recent
      hit_age = shadow_age[idx];
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (shadow_valid[i] && shadow_age[i] < hit_age) shadow_age[i]++;
      end
      shadow_age[idx] = 0;
      if (shadow_count > eff_cap) begin
        victim = oldest_entry();
        if (victim >= 0 && victim != idx) begin
          gone                 = 1'b1;
          gone_tag             = shadow_tag[victim];
          shadow_valid[victim] = 1'b0;
          shadow_age[victim]   = 0;
          shadow_count--;
        end
      end
    end else begin
      // miss: lowest free slot while there is room, else reuse the oldest
      if (shadow_count < eff_cap) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (idx < 0 && !shadow_valid[i]) idx = i;
        end
      end
      if (idx >= 0) begin
        shadow_count++;
      end else begin
        idx = oldest_entry();
        if (idx < 0) idx = 0;
        if (shadow_valid[idx]) begin
          gone              = 1'b1;
          gone_tag          = shadow_tag[idx];
          shadow_valid[idx] = 1'b0;
        end else begin
          shadow_count++;
        end
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (shadow_valid[i]) shadow_age[i]++;
      end
      shadow_valid[idx] = 1'b1;
      shadow_tag[idx]   = tag;
      shadow_age[idx]   = 0;
    end
    res.slot         = idx[lkc_pkg::SLOT_W-1:0];
    res.evicted      = gone;
    res.evicted_key  = gone ? gone_tag[lkc_pkg::KEY_W-1:0] : '0;
    res.evicted_side = gone ? gone_tag[lkc_pkg::KEY_W] : 1'b0;
    return res;
  endfunction

  // one request transfer after a gap; queue the expected result
  task automatic send_lookup(input lkc_pkg::req_t item, input int gap,
                             input logic typed, input lkc_pkg::rsp_t typed_rsp);
    lkc_pkg::rsp_t predicted;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    predicted = lru_lookup(item);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  // capacity write once every expected result has come back
  task automatic write_capacity(input logic [lkc_pkg::CAP_W-1:0] value);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    shadow_cap = value;
    cfg_wr_en  <= 1'b0;
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin
    lkc_pkg::rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transfer: slot %0d", rsp.slot);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
          errors++;
        end
        if (rsp.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
          errors++;
        end
        if (rsp.evicted !== want.evicted) begin
          $error("evicted: expected %0d, actual %0d", want.evicted, rsp.evicted);
          errors++;
        end
        if (rsp.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, actual %h", want.evicted_key,
                 rsp.evicted_key);
          errors++;
        end
        if (rsp.evicted_side !== want.evicted_side) begin
          $error("evicted_side: expected %0d, actual %0d", want.evicted_side,
                 rsp.evicted_side);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [lkc_pkg::CAP_W-1:0] phase_cap [8];
    lkc_pkg::req_t             key_pool [32];
    int                        pool_len;
    logic                      burst;
    lkc_pkg::req_t             item;
    lkc_pkg::rsp_t             typed_rsp;
    phase_cap   = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd9};
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    errors      = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
      shadow_age[i]   = 0;
    end
    shadow_count = 0;
    shadow_cap   = lkc_pkg::CAP_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CAP) begin
        write_capacity(plan[r].cap);
      end else begin
        item.key_value         = plan[r].key_value;
        item.side              = plan[r].side;
        typed_rsp              = '0;
        typed_rsp.hit          = plan[r].want_hit;
        typed_rsp.slot         = plan[r].want_slot;
        send_lookup(item, $urandom_range(0, 3), plan[r].typed, typed_rsp);
      end
    end

    // random phases, one capacity setting each
    burst = 1'b0;
    foreach (phase_cap[p]) begin
      write_capacity(phase_cap[p]);
      pool_len = $urandom_range(2, 24);
      for (int i = 0; i < pool_len; i++) begin
        key_pool[i].key_value = $urandom;
        key_pool[i].side      = 1'($urandom_range(0, 1));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) burst = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) == 0) begin
          item.key_value = $urandom;
          item.side      = 1'($urandom_range(0, 1));
        end else begin
          item = key_pool[$urandom_range(0, pool_len - 1)];
        end
        send_lookup(item, burst ? 0 : $urandom_range(0, 3), 1'b0, '0);
      end
    end

    // drain and let any stray result show up
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (NUM_ENTRIES + 4) @(posedge clk);
    if (errors == 0) begin
      $display("lru_key_cache_tracker test passed");
    end else begin
      $display("lru_key_cache_tracker test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("lru_key_cache_tracker test failed");
    $finish;
  end

endmodule

>>> files.f
src/lkc_pkg.sv
src/lkc_cell.sv
src/lru_key_cache_tracker.sv
test/tb_top.sv
